### rtl/lmfb_pkg.sv
package lmfb_pkg;

    localparam int CH_W     = 8;
    localparam int FACTOR_W = 9;
    localparam int PIX_W    = 3 * CH_W;
    localparam int IDX_W    = 3;

    localparam logic [FACTOR_W-1:0] Q8_ONE = 9'd256;

    typedef enum logic [2:0] {
        OP_FADE       = 3'd0,
        OP_FADE_FLOOR = 3'd1,
        OP_FILL_BAR   = 3'd2,
        OP_FILL_ALL   = 3'd3,
        OP_BLEND      = 3'd4,
        OP_SHOW       = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ALU_FADE  = 2'd0,
        ALU_FLOOR = 2'd1,
        ALU_BLEND = 2'd2
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t           mode;
        logic [FACTOR_W-1:0] factor;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
    } alu_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] bar;
        logic [IDX_W-1:0] pixel;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             last;
    } out_beat_t;

endpackage

### rtl/lmfb_store.sv
module lmfb_store
    import lmfb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem_reg [DEPTH];
    logic [PIX_W-1:0] rd_q_reg;
    logic             hit_q_reg;
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem_reg[rd_addr];
        end
    end

    // unwritten entries read as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            hit_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_q_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_q_reg ? rd_q_reg : '0;

endmodule

### rtl/lmfb_alu.sv
module lmfb_alu
    import lmfb_pkg::*;
(
    input  alu_ctrl_t        ctrl,
    input  logic [PIX_W-1:0] pix_old,
    output logic [PIX_W-1:0] pix_new
);

    function automatic logic [CH_W-1:0] calc_ch(
        input alu_mode_t           mode,
        input logic [FACTOR_W-1:0] f,
        input logic [CH_W-1:0]     c,
        input logic [CH_W-1:0]     col
    );
        logic [16:0]         prod;
        logic [16:0]         mix;
        logic [FACTOR_W-1:0] inv;
        logic [CH_W-1:0]     scaled;
        logic [CH_W-1:0]     res;
        begin
            prod   = 17'(c) * 17'(f);
            inv    = Q8_ONE - f;
            mix    = 17'(c) * 17'(inv) + 17'(col) * 17'(f);
            scaled = prod[15:8];
            unique case (mode)
                ALU_FADE:  res = scaled;
                ALU_FLOOR: res = (scaled < col) ? col : scaled;
                ALU_BLEND: res = mix[15:8];
                default:   res = scaled;
            endcase
            calc_ch = res;
        end
    endfunction

    always_comb
    begin
        pix_new[23:16] = calc_ch(ctrl.mode, ctrl.factor, pix_old[23:16], ctrl.red);
        pix_new[15:8]  = calc_ch(ctrl.mode, ctrl.factor, pix_old[15:8], ctrl.green);
        pix_new[7:0]   = calc_ch(ctrl.mode, ctrl.factor, pix_old[7:0], ctrl.blue);
    end

endmodule

### rtl/lmfb_out_buf.sv
module lmfb_out_buf
    import lmfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  out_beat_t  push_beat,
    input  logic       pop,
    output out_beat_t  head,
    output logic       head_valid,
    output logic [1:0] level
);

    out_beat_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] level_reg;
    logic [1:0] level_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (level_reg != 2'd0);
    assign level      = level_reg;

endmodule

### rtl/led_matrix_fade_blend_engine_core.sv
// LED frame store of BARS x HEIGHT RGB pixels, black after reset, held in one
// synchronous RAM with per-entry valid bits (no clearing pass is needed).
// Fade, fade to floor and show walk the whole RAM at one read per cycle, show
// pausing its reads while the two-entry output buffer has no room. Fill all
// writes every pixel, fill bar the HEIGHT pixels of one bar, and blend pixel
// reads one pixel and writes it back, all through the single RAM port pair.
// Show beats leave through that buffer, so a new item is taken once the RAM
// walk and its drain state end, even while shown pixels wait to be taken.
module led_matrix_fade_blend_engine_core
    import lmfb_pkg::*;
#(
    parameter int BARS   = 8,
    parameter int HEIGHT = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [IDX_W-1:0]    bar_index,
    input  logic [IDX_W-1:0]    pixel_index,
    input  logic [FACTOR_W-1:0] factor_q8,
    input  logic [CH_W-1:0]     red_value,
    input  logic [CH_W-1:0]     green_value,
    input  logic [CH_W-1:0]     blue_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    out_bar,
    output logic [IDX_W-1:0]    out_pixel,
    output logic [CH_W-1:0]     out_red,
    output logic [CH_W-1:0]     out_green,
    output logic [CH_W-1:0]     out_blue,
    output logic                last_pixel
);

    localparam int NUM_PIX = BARS * HEIGHT;
    localparam int AW      = (NUM_PIX > 1) ? $clog2(NUM_PIX) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FILL  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    logic [AW-1:0]    last_reg;
    logic [AW-1:0]    last_next;
    logic             show_reg;
    logic             show_next;
    alu_ctrl_t        ctrl_reg;
    alu_ctrl_t        ctrl_next;
    logic [IDX_W-1:0] bar_cnt_reg;
    logic [IDX_W-1:0] bar_cnt_next;
    logic [IDX_W-1:0] pix_cnt_reg;
    logic [IDX_W-1:0] pix_cnt_next;
    logic             pend_reg;
    logic             pend_next;
    logic [AW-1:0]    pend_addr_reg;
    logic [AW-1:0]    pend_addr_next;
    logic [IDX_W-1:0] pend_bar_reg;
    logic [IDX_W-1:0] pend_bar_next;
    logic [IDX_W-1:0] pend_pix_reg;
    logic [IDX_W-1:0] pend_pix_next;
    logic             pend_last_reg;
    logic             pend_last_next;

    logic                issue;
    logic                space_ok;
    logic [2:0]          occ;
    logic                pop;
    logic [1:0]          buf_level;
    logic                bar_ok;
    logic                pix_ok;
    logic [6:0]          bar_base;
    logic [6:0]          pix_lin;
    logic [6:0]          bar_end;
    logic [FACTOR_W-1:0] f_clamp;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_data;
    logic [PIX_W-1:0] rd_data;
    logic [PIX_W-1:0] alu_out;
    out_beat_t        push_beat;
    out_beat_t        head;

    lmfb_store #(
        .DEPTH (NUM_PIX),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    lmfb_alu u_alu (
        .ctrl    (ctrl_reg),
        .pix_old (rd_data),
        .pix_new (alu_out)
    );

    lmfb_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (pend_reg & show_reg),
        .push_beat  (push_beat),
        .pop        (pop),
        .head       (head),
        .head_valid (out_valid),
        .level      (buf_level)
    );

    assign pop      = out_valid & out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign occ      = 3'(buf_level) + 3'(pend_reg) - 3'(pop);
    assign space_ok = (occ < 3'd2);
    assign issue    = (state_reg == ST_READ) && (!show_reg || space_ok);

    assign bar_ok   = ({1'b0, bar_index} < 4'(BARS));
    assign pix_ok   = ({1'b0, pixel_index} < 4'(HEIGHT));
    assign bar_base = 7'(bar_index) * 7'(HEIGHT);
    assign pix_lin  = bar_base + 7'(pixel_index);
    assign bar_end  = bar_base + 7'(HEIGHT - 1);
    assign f_clamp  = (factor_q8 > Q8_ONE) ? Q8_ONE : factor_q8;

    assign push_beat.bar   = pend_bar_reg;
    assign push_beat.pixel = pend_pix_reg;
    assign push_beat.red   = rd_data[23:16];
    assign push_beat.green = rd_data[15:8];
    assign push_beat.blue  = rd_data[7:0];
    assign push_beat.last  = pend_last_reg;

    always_comb
    begin
        if (state_reg == ST_FILL)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = {ctrl_reg.red, ctrl_reg.green, ctrl_reg.blue};
        end
        else
        begin
            wr_en   = pend_reg & ~show_reg;
            wr_addr = pend_addr_reg;
            wr_data = alu_out;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        show_next      = show_reg;
        ctrl_next      = ctrl_reg;
        bar_cnt_next   = bar_cnt_reg;
        pix_cnt_next   = pix_cnt_reg;
        pend_next      = issue;
        pend_addr_next = addr_reg;
        pend_bar_next  = bar_cnt_reg;
        pend_pix_next  = pix_cnt_reg;
        pend_last_next = (addr_reg == last_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl_next.factor = f_clamp;
                    ctrl_next.red    = red_value;
                    ctrl_next.green  = green_value;
                    ctrl_next.blue   = blue_value;
                    ctrl_next.mode   = ALU_FADE;
                    show_next        = 1'b0;
                    addr_next        = '0;
                    last_next        = AW'(NUM_PIX - 1);
                    bar_cnt_next     = '0;
                    pix_cnt_next     = '0;
                    unique case (opcode_t'(opcode))
                        OP_FADE:
                        begin
                            state_next = ST_READ;
                        end
                        OP_FADE_FLOOR:
                        begin
                            ctrl_next.mode = ALU_FLOOR;
                            state_next     = ST_READ;
                        end
                        OP_FILL_BAR:
                        begin
                            addr_next = AW'(bar_base);
                            last_next = AW'(bar_end);
                            if (bar_ok)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        OP_FILL_ALL:
                        begin
                            state_next = ST_FILL;
                        end
                        OP_BLEND:
                        begin
                            ctrl_next.mode = ALU_BLEND;
                            addr_next      = AW'(pix_lin);
                            last_next      = AW'(pix_lin);
                            if (bar_ok && pix_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_SHOW:
                        begin
                            show_next  = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + AW'(1);
                    if (pix_cnt_reg == IDX_W'(HEIGHT - 1))
                    begin
                        pix_cnt_next = '0;
                        bar_cnt_next = bar_cnt_reg + IDX_W'(1);
                    end
                    else
                    begin
                        pix_cnt_next = pix_cnt_reg + IDX_W'(1);
                    end
                    if (addr_reg == last_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            show_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            show_reg  <= show_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        ctrl_reg      <= ctrl_next;
        bar_cnt_reg   <= bar_cnt_next;
        pix_cnt_reg   <= pix_cnt_next;
        pend_addr_reg <= pend_addr_next;
        pend_bar_reg  <= pend_bar_next;
        pend_pix_reg  <= pend_pix_next;
        pend_last_reg <= pend_last_next;
    end

    assign out_bar    = head.bar;
    assign out_pixel  = head.pixel;
    assign out_red    = head.red;
    assign out_green  = head.green;
    assign out_blue   = head.blue;
    assign last_pixel = head.last;

endmodule

### test/testbench.sv
module testbench;
    import lmfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BARS         = 8;
    localparam int HEIGHT       = 8;
    localparam int PIXELS       = BARS * HEIGHT;
    localparam int RANDOM_CMDS  = 430;
    localparam int TAIL_CMDS    = 40;
    localparam int SETTLE_CYC   = 200;
    localparam int STALL_LIMIT  = 3000;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]          op;
        logic [IDX_W-1:0]    bar;
        logic [IDX_W-1:0]    pix;
        logic [FACTOR_W-1:0] factor;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        bit                  drain;
    } frame_cmd_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [2:0]          opcode      = '0;
    logic [IDX_W-1:0]    bar_index   = '0;
    logic [IDX_W-1:0]    pixel_index = '0;
    logic [FACTOR_W-1:0] factor_q8   = '0;
    logic [CH_W-1:0]     red_value   = '0;
    logic [CH_W-1:0]     green_value = '0;
    logic [CH_W-1:0]     blue_value  = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [IDX_W-1:0]    out_bar;
    logic [IDX_W-1:0]    out_pixel;
    logic [CH_W-1:0]     out_red;
    logic [CH_W-1:0]     out_green;
    logic [CH_W-1:0]     out_blue;
    logic                last_pixel;

    frame_cmd_t  cmd_q[$];
    frame_cmd_t  cmd_on_bus;
    out_beat_t   shown_pixels_q[$];
    logic [23:0] frame_px [PIXELS];

    int  mismatches  = 0;
    int  send_gap    = 0;
    int  recv_stall  = 0;
    int  quiet_count = 0;
    bit  send_quiet  = 1'b0;
    bit  recv_quiet  = 1'b0;
    bit  tail_phase  = 1'b0;
    bit  cmd_fire;

    led_matrix_fade_blend_engine_core #(
        .BARS   (BARS),
        .HEIGHT (HEIGHT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .bar_index   (bar_index),
        .pixel_index (pixel_index),
        .factor_q8   (factor_q8),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bar     (out_bar),
        .out_pixel   (out_pixel),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .last_pixel  (last_pixel)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [CH_W-1:0] scale_ch(int unsigned ch, int unsigned f,
                                                 int unsigned fl, bit use_floor);
        int unsigned x;
        x = (ch * f) >> 8;
        if (use_floor && x < fl)
            x = fl;
        return x[CH_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] blend_ch(int unsigned old_ch, int unsigned new_ch,
                                                 int unsigned f);
        int unsigned x;
        x = (old_ch * (256 - f) + new_ch * f) >> 8;
        return x[CH_W-1:0];
    endfunction

    function automatic void update_frame(frame_cmd_t c);
        int unsigned f;
        int          k;
        bit          use_floor;
        logic [23:0] p;
        out_beat_t   beat;
        f = (c.factor > Q8_ONE) ? 32'(Q8_ONE) : 32'(c.factor);
        use_floor = (c.op == OP_FADE_FLOOR);
        case (c.op)
            OP_FADE, OP_FADE_FLOOR:
            begin
                for (k = 0; k < PIXELS; k++)
                begin
                    p = frame_px[k];
                    frame_px[k] = {scale_ch(p[23:16], f, c.red, use_floor),
                                   scale_ch(p[15:8], f, c.green, use_floor),
                                   scale_ch(p[7:0], f, c.blue, use_floor)};
                end
            end
            OP_FILL_BAR:
            begin
                if (c.bar < BARS)
                    for (k = 0; k < HEIGHT; k++)
                        frame_px[c.bar * HEIGHT + k] = {c.red, c.green, c.blue};
            end
            OP_FILL_ALL:
            begin
                for (k = 0; k < PIXELS; k++)
                    frame_px[k] = {c.red, c.green, c.blue};
            end
            OP_BLEND:
            begin
                if (c.bar < BARS && c.pix < HEIGHT)
                begin
                    k = c.bar * HEIGHT + c.pix;
                    p = frame_px[k];
                    frame_px[k] = {blend_ch(p[23:16], c.red, f),
                                   blend_ch(p[15:8], c.green, f),
                                   blend_ch(p[7:0], c.blue, f)};
                end
            end
            OP_SHOW:
            begin
                for (k = 0; k < PIXELS; k++)
                begin
                    beat.bar   = IDX_W'(k / HEIGHT);
                    beat.pixel = IDX_W'(k % HEIGHT);
                    beat.red   = frame_px[k][23:16];
                    beat.green = frame_px[k][15:8];
                    beat.blue  = frame_px[k][7:0];
                    beat.last  = (k == PIXELS - 1);
                    shown_pixels_q.push_back(beat);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic frame_cmd_t make_cmd(logic [2:0] op, int bar, int pix, int f,
                                            int r, int g, int b, bit drain);
        frame_cmd_t c;
        c.op     = op;
        c.bar    = IDX_W'(bar);
        c.pix    = IDX_W'(pix);
        c.factor = FACTOR_W'(f);
        c.red    = CH_W'(r);
        c.green  = CH_W'(g);
        c.blue   = CH_W'(b);
        c.drain  = drain;
        return c;
    endfunction

    function automatic int pick_factor();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 256;
            2:       return $urandom_range(257, 511);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_channel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic frame_cmd_t random_cmd(bit drain);
        int         sel;
        logic [2:0] op;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            op = OP_SHOW;
        else if (sel < 22)
            op = OP_FADE;
        else if (sel < 32)
            op = OP_FADE_FLOOR;
        else if (sel < 47)
            op = OP_FILL_BAR;
        else if (sel < 52)
            op = OP_FILL_ALL;
        else if (sel < 96)
            op = OP_BLEND;
        else if (sel < 98)
            op = OP_SPARE_6;
        else
            op = OP_SPARE_7;
        return make_cmd(op, $urandom_range(0, 7), $urandom_range(0, 7), pick_factor(),
                        pick_channel(), pick_channel(), pick_channel(), drain);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            opcode      <= '0;
            bar_index   <= '0;
            pixel_index <= '0;
            factor_q8   <= '0;
            red_value   <= '0;
            green_value <= '0;
            blue_value  <= '0;
            send_gap    = 0;
        end
        else
        begin
            cmd_fire = in_valid && in_ready;
            if (cmd_fire)
            begin
                update_frame(cmd_on_bus);
                if (!send_quiet && !tail_phase && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            if ($urandom_range(0, 149) == 0)
                send_quiet = !send_quiet;
            tail_phase = (cmd_q.size() < TAIL_CMDS);

            if (in_valid && !cmd_fire)
            begin
                // hold the beat until taken
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0 && !(cmd_q[0].drain && shown_pixels_q.size() != 0))
            begin
                cmd_on_bus = cmd_q.pop_front();
                in_valid    <= 1'b1;
                opcode      <= cmd_on_bus.op;
                bar_index   <= cmd_on_bus.bar;
                pixel_index <= cmd_on_bus.pix;
                factor_q8   <= cmd_on_bus.factor;
                red_value   <= cmd_on_bus.red;
                green_value <= cmd_on_bus.green;
                blue_value  <= cmd_on_bus.blue;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (shown_pixels_q.size() == 0)
                begin
                    $error("output beat with no shown pixel pending: bar %0d pixel %0d",
                           out_bar, out_pixel);
                    mismatches++;
                end
                else
                begin
                    out_beat_t want;
                    want = shown_pixels_q.pop_front();
                    check_field("out_bar", want.bar, out_bar);
                    check_field("out_pixel", want.pixel, out_pixel);
                    check_field("out_red", want.red, out_red);
                    check_field("out_green", want.green, out_green);
                    check_field("out_blue", want.blue, out_blue);
                    check_field("last_pixel", want.last, last_pixel);
                end
            end
            if ($urandom_range(0, 149) == 0)
                recv_quiet = !recv_quiet;
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!recv_quiet && !tail_phase && $urandom_range(0, 4) == 0)
                    recv_stall = $urandom_range(1, 11);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT)
            begin
                $display("led_matrix_fade_blend_engine_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < PIXELS; i++)
            frame_px[i] = '0;

        cmd_q.push_back(make_cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_FILL_ALL, 5, 3, 100, 255, 255, 255, 1'b1));
        cmd_q.push_back(make_cmd(OP_FADE, 0, 0, 256, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE, 7, 7, 511, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE, 2, 1, 128, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_SHOW, 7, 7, 511, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_FILL_BAR, 0, 6, 0, 8'h12, 8'h34, 8'h56, 1'b0));
        cmd_q.push_back(make_cmd(OP_FILL_BAR, 7, 1, 511, 8'hAA, 8'h55, 8'hF0, 1'b0));
        cmd_q.push_back(make_cmd(OP_BLEND, 7, 7, 0, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_BLEND, 0, 0, 256, 1, 2, 3, 1'b0));
        cmd_q.push_back(make_cmd(OP_BLEND, 3, 5, 300, 200, 10, 90, 1'b0));
        cmd_q.push_back(make_cmd(OP_BLEND, 5, 2, 77, 255, 0, 128, 1'b0));
        cmd_q.push_back(make_cmd(OP_BLEND, 0, 7, 255, 0, 255, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE_FLOOR, 4, 4, 200, 8'h40, 8'h00, 8'h80, 1'b0));
        cmd_q.push_back(make_cmd(OP_SHOW, 1, 2, 3, 4, 5, 6, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE_FLOOR, 0, 0, 0, 8'h10, 8'h20, 8'h30, 1'b0));
        cmd_q.push_back(make_cmd(OP_SPARE_6, 7, 7, 511, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_SPARE_7, 7, 7, 511, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_SHOW, 0, 0, 0, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE_FLOOR, 6, 6, 511, 255, 255, 255, 1'b0));
        cmd_q.push_back(make_cmd(OP_FILL_ALL, 0, 0, 0, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_FADE, 0, 0, 0, 0, 0, 0, 1'b0));
        cmd_q.push_back(make_cmd(OP_SHOW, 7, 7, 256, 0, 0, 0, 1'b0));
        for (i = 0; i < RANDOM_CMDS; i++)
            cmd_q.push_back(random_cmd(i % 60 == 59));

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_q.size() != 0 || in_valid || shown_pixels_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);

        if (mismatches == 0 && shown_pixels_q.size() == 0)
            $display("led_matrix_fade_blend_engine_core test passed");
        else
            $display("led_matrix_fade_blend_engine_core test failed");
        $finish;
    end

endmodule
